// File: sv/sgm_pca_pkg.sv
// Shared definitions for the semi-global matching path cost aggregation block.
// Holds default sizes, register reset values and configuration register indexes.
// Used by the top level and by its port checker.
package sgm_pca_pkg;

    localparam int MAX_DISPARITIES_DEF = 128;
    localparam int COST_BITS_DEF       = 20;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int PEN_W       = 8;
    localparam int UNARY_W     = 8;
    localparam int INDEX_W     = 7;

    localparam logic [PEN_W-1:0] SMALL_PENALTY_RST   = 8'd5;
    localparam logic [PEN_W-1:0] LARGE_PENALTY_RST   = 8'd60;
    localparam logic [PEN_W-1:0] DISPARITY_COUNT_RST = 8'd81;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SMALL_PENALTY   = 2'd0,
        CFG_LARGE_PENALTY   = 2'd1,
        CFG_DISPARITY_COUNT = 2'd2
    } t_cfg_index;

endpackage

// File: sv/sgm_path_cost_aggregation_top.sv
// Path cost aggregation along one scan path for semi-global matching.
// Depends on sgm_pca_pkg for sizes, reset values and register indexes.
// Holds the cost line memory, the aggregation datapath and the output register.

// The block takes one matching cost word per cycle when it is not stalled, disparities 0
// to D-1 of each pixel in order. For each accepted word it offers one path cost word,
// which passes through the aggregation stage register and then the output register, where
// it waits while the output side is stalled. The sustained rate is one word per clock
// when no stall holds the flow. It is set by the cost line memory, which gives two reads
// (disparities d and d+1 of the previous pixel) and takes one write (the new cost at d)
// per cycle; the d-1 neighbor is kept in a register. The memory holds the previous
// pixel's costs and is overwritten in place as the current pixel is built, so no copy
// happens at a pixel boundary. Its contents are undefined after reset: the first pixel
// of a path must be marked as a path start. The user must write the configuration
// registers only while no word is in flight; the block itself does not enforce this.
module sgm_path_cost_aggregation_top #(
    parameter int MAX_DISPARITIES = sgm_pca_pkg::MAX_DISPARITIES_DEF,
    parameter int COST_BITS       = sgm_pca_pkg::COST_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sgm_pca_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sgm_pca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sgm_pca_pkg::UNARY_W-1:0]     i_unary_cost,
    input  logic                                i_path_start,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [COST_BITS-1:0]                o_path_cost,
    output logic [sgm_pca_pkg::INDEX_W-1:0]     o_disparity_index,
    output logic                                o_last_disparity
);

    localparam int DW = $clog2(MAX_DISPARITIES);
    localparam int LW = $clog2(MAX_DISPARITIES + 1);
    localparam int CW = (LW > sgm_pca_pkg::PEN_W) ? LW : sgm_pca_pkg::PEN_W;
    localparam int C  = COST_BITS;

    localparam logic [C-1:0]  COST_MAX = '1;
    localparam logic [CW-1:0] LEVELS_MIN = CW'(2);
    localparam logic [CW-1:0] LEVELS_MAX = CW'(MAX_DISPARITIES);
    localparam logic [DW-1:0] D_TOP = DW'(MAX_DISPARITIES - 1);

    // Configuration registers.
    logic [sgm_pca_pkg::PEN_W-1:0] r_small_pen;
    logic [sgm_pca_pkg::PEN_W-1:0] r_large_pen;
    logic [sgm_pca_pkg::PEN_W-1:0] r_disp_count;

    // Disparity of the next word.
    logic [DW-1:0] r_cnt;
    logic [DW-1:0] n_cnt;

    // Aggregation stage.
    logic                            r_s1_v;
    logic [sgm_pca_pkg::UNARY_W-1:0] r_s1_unary;
    logic                            r_s1_start;
    logic [DW-1:0]                   r_s1_d;
    logic                            r_s1_last;

    // Previous pixel costs around the current disparity.
    logic [C-1:0] r_pm;
    logic [C-1:0] r_m0;
    logic [C-1:0] r_m1;
    logic         r_byp0;
    logic         r_byp1;
    logic [C-1:0] r_byp_data;

    logic [C-1:0] r_prev_min;
    logic [C-1:0] r_run_min;

    // Output register.
    logic          r_o_v;
    logic [C-1:0]  r_o_cost;
    logic [DW-1:0] r_o_d;
    logic          r_o_last;

    logic [C-1:0] mem [MAX_DISPARITIES];

    logic          out_ready;
    logic          s1_adv;
    logic          in_acc;
    logic [CW-1:0] count_ext;
    logic [CW-1:0] levels;
    logic          cnt_last;
    logic [DW-1:0] rd_addr0;
    logic [DW-1:0] rd_addr1;
    logic [C-1:0]  p0;
    logic [C-1:0]  pn;
    logic [C:0]    c_same;
    logic [C:0]    c_jump;
    logic [C:0]    c_lo;
    logic [C:0]    c_hi;
    logic [C:0]    best_a;
    logic [C:0]    best_b;
    logic [C:0]    best;
    logic [C+1:0]  sum;
    logic [C-1:0]  cost;
    logic [C-1:0]  run_min_next;

    assign out_ready = !r_o_v || !i_stall;
    assign s1_adv    = r_s1_v && out_ready;
    assign o_stall   = r_s1_v && !out_ready;
    assign in_acc    = i_valid && !o_stall;

    // Levels in use, clamped to the supported range.
    always_comb begin
        count_ext = CW'(r_disp_count);
        if (count_ext < LEVELS_MIN) begin
            levels = LEVELS_MIN;
        end else if (count_ext > LEVELS_MAX) begin
            levels = LEVELS_MAX;
        end else begin
            levels = count_ext;
        end
        cnt_last = CW'(r_cnt) >= (levels - CW'(1));
        n_cnt    = cnt_last ? '0 : r_cnt + DW'(1);
        rd_addr0 = r_cnt;
        rd_addr1 = (r_cnt == D_TOP) ? r_cnt : r_cnt + DW'(1);
    end

    // A cost written in the same cycle as the read is taken from the bypass.
    assign p0 = r_byp0 ? r_byp_data : r_m0;
    assign pn = r_byp1 ? r_byp_data : r_m1;

    always_comb begin
        c_same = {1'b0, p0};
        c_jump = {1'b0, r_prev_min} + (C+1)'(r_large_pen);
        c_lo   = (r_s1_d != '0) ? {1'b0, r_pm} + (C+1)'(r_small_pen) : '1;
        c_hi   = !r_s1_last ? {1'b0, pn} + (C+1)'(r_small_pen) : '1;
        best_a = (c_same < c_jump) ? c_same : c_jump;
        best_b = (c_lo < c_hi) ? c_lo : c_hi;
        best   = (best_a < best_b) ? best_a : best_b;
        if (r_s1_start) begin
            sum = (C+2)'(r_s1_unary);
        end else begin
            sum = (C+2)'(r_s1_unary) + {1'b0, best};
        end
        cost = (sum > (C+2)'(COST_MAX)) ? COST_MAX : sum[C-1:0];
        run_min_next = (cost < r_run_min) ? cost : r_run_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_pen  <= sgm_pca_pkg::SMALL_PENALTY_RST;
            r_large_pen  <= sgm_pca_pkg::LARGE_PENALTY_RST;
            r_disp_count <= sgm_pca_pkg::DISPARITY_COUNT_RST;
        end else if (i_cfg_we) begin
            case (sgm_pca_pkg::t_cfg_index'(i_cfg_index))
                sgm_pca_pkg::CFG_SMALL_PENALTY:   r_small_pen  <= i_cfg_data;
                sgm_pca_pkg::CFG_LARGE_PENALTY:   r_large_pen  <= i_cfg_data;
                sgm_pca_pkg::CFG_DISPARITY_COUNT: r_disp_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_v     <= 1'b0;
            r_prev_min <= '0;
            r_run_min  <= COST_MAX;
            r_o_v      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= n_cnt;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_last) begin
                    r_prev_min <= run_min_next;
                    r_run_min  <= COST_MAX;
                end else begin
                    r_run_min  <= run_min_next;
                end
            end
            if (out_ready) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_unary <= i_unary_cost;
            r_s1_start <= i_path_start;
            r_s1_d     <= r_cnt;
            r_s1_last  <= cnt_last;
            // The center cost of the previous word is the lower neighbor of this one.
            r_pm       <= p0;
            r_byp0     <= s1_adv && (r_s1_d == rd_addr0);
            r_byp1     <= s1_adv && (r_s1_d == rd_addr1);
            r_byp_data <= cost;
        end
        if (s1_adv) begin
            r_o_cost <= cost;
            r_o_d    <= r_s1_d;
            r_o_last <= r_s1_last;
        end
    end

    // Cost line memory: one write and two reads per cycle.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem[r_s1_d] <= cost;
        end
        if (in_acc) begin
            r_m0 <= mem[rd_addr0];
            r_m1 <= mem[rd_addr1];
        end
    end

    assign o_valid           = r_o_v;
    assign o_path_cost       = r_o_cost;
    assign o_disparity_index = sgm_pca_pkg::INDEX_W'(r_o_d);
    assign o_last_disparity  = r_o_last;

endmodule

// File: sv/sgm_pca_checker.sv
// Port-level checker for the path cost aggregation top level, with its bind.
// Depends on sgm_pca_pkg for port widths.
// Watches handshake behavior on both word channels.
module sgm_pca_checker #(
    parameter int COST_BITS = sgm_pca_pkg::COST_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [COST_BITS-1:0]                o_path_cost,
    input logic [sgm_pca_pkg::INDEX_W-1:0]     o_disparity_index,
    input logic                                o_last_disparity
);

    // A word waiting at the output stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_path_cost) && $stable(o_disparity_index)
            && $stable(o_last_disparity))
        else $error("stalled output word changed");

    // The input side is held off only when the output register is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind sgm_path_cost_aggregation_top sgm_pca_checker #(
    .COST_BITS(COST_BITS)
) u_sgm_pca_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_path_cost       (o_path_cost),
    .o_disparity_index (o_disparity_index),
    .o_last_disparity  (o_last_disparity)
);

// File: tb/sv/sgm_path_cost_checker.sv
`timescale 1ns / 1ps
// Checker for the path cost aggregation block: watches the register port and both word
// channels, predicts every path cost word and compares it with what the block returns.
// Depends on sgm_pca_pkg for widths, register reset values and register indexes.
module sgm_path_cost_checker #(
    parameter int MAX_DISPARITIES = sgm_pca_pkg::MAX_DISPARITIES_DEF,
    parameter int COST_BITS       = sgm_pca_pkg::COST_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sgm_pca_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sgm_pca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [sgm_pca_pkg::UNARY_W-1:0]     i_unary_cost,
    input  logic                                i_path_start,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [COST_BITS-1:0]                i_path_cost,
    input  logic [sgm_pca_pkg::INDEX_W-1:0]     i_disparity_index,
    input  logic                                i_last_disparity,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam int SUM_W = COST_BITS + 2;
    localparam logic [SUM_W-1:0] COST_SAT = {2'b00, {COST_BITS{1'b1}}};

    typedef struct packed {
        logic [COST_BITS-1:0]            path_cost;
        logic [sgm_pca_pkg::INDEX_W-1:0] disparity_index;
        logic                            last_disparity;
    } t_path_word;

    t_path_word expected_path_costs[$];

    logic [sgm_pca_pkg::PEN_W-1:0] small_penalty;
    logic [sgm_pca_pkg::PEN_W-1:0] large_penalty;
    logic [sgm_pca_pkg::PEN_W-1:0] disparity_count;
    logic [COST_BITS-1:0] prev_costs [MAX_DISPARITIES];
    logic [COST_BITS-1:0] pixel_costs [MAX_DISPARITIES];
    logic [COST_BITS-1:0] prev_min;
    logic [COST_BITS-1:0] pixel_min;
    int unsigned          next_disparity;
    int                   mismatches = 0;
    int                   checked = 0;
    int                   in_flight = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = in_flight;
    assign o_checked    = checked;

    function automatic logic [SUM_W-1:0] lesser_cost(input logic [SUM_W-1:0] a,
                                                     input logic [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Works out the path cost of one accepted cost word and advances the pixel state.
    task automatic aggregate_cost(input logic [sgm_pca_pkg::UNARY_W-1:0] unary,
                                  input logic start);
        int unsigned      levels;
        int unsigned      d;
        int               i;
        logic             is_last;
        logic [SUM_W-1:0] best;
        logic [SUM_W-1:0] cost;
        t_path_word       w;
        levels = (disparity_count < 2) ? 2 :
                 (disparity_count > MAX_DISPARITIES) ? MAX_DISPARITIES : disparity_count;
        d = (next_disparity >= MAX_DISPARITIES) ? MAX_DISPARITIES - 1 : next_disparity;
        // A count lowered below the current level closes the pixel on this word.
        is_last = (d >= levels - 1);
        if (start) begin
            cost = SUM_W'(unary);
        end else begin
            best = lesser_cost(SUM_W'(prev_costs[d]),
                               SUM_W'(prev_min) + SUM_W'(large_penalty));
            if (d > 0)
                best = lesser_cost(best, SUM_W'(prev_costs[d - 1]) + SUM_W'(small_penalty));
            if (!is_last)
                best = lesser_cost(best, SUM_W'(prev_costs[d + 1]) + SUM_W'(small_penalty));
            cost = best + SUM_W'(unary);
        end
        cost = lesser_cost(cost, COST_SAT);
        pixel_costs[d] = cost[COST_BITS-1:0];
        if (cost[COST_BITS-1:0] < pixel_min)
            pixel_min = cost[COST_BITS-1:0];
        w.path_cost       = cost[COST_BITS-1:0];
        w.disparity_index = d[sgm_pca_pkg::INDEX_W-1:0];
        w.last_disparity  = is_last;
        expected_path_costs.push_back(w);
        if (is_last) begin
            for (i = 0; i < MAX_DISPARITIES; i++)
                prev_costs[i] = pixel_costs[i];
            prev_min       = pixel_min;
            pixel_min      = '1;
            next_disparity = 0;
        end else begin
            next_disparity = d + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_path_word got;
        t_path_word want;
        if (!i_rst_n) begin
            small_penalty   = sgm_pca_pkg::SMALL_PENALTY_RST;
            large_penalty   = sgm_pca_pkg::LARGE_PENALTY_RST;
            disparity_count = sgm_pca_pkg::DISPARITY_COUNT_RST;
            prev_min        = '0;
            pixel_min       = '1;
            next_disparity  = 0;
            expected_path_costs.delete();
        end else begin
            // Results go first: a word accepted at this edge cannot leave at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got.path_cost       = i_path_cost;
                got.disparity_index = i_disparity_index;
                got.last_disparity  = i_last_disparity;
                if (expected_path_costs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected path cost word: cost %0d index %0d last %0b",
                                 got.path_cost, got.disparity_index, got.last_disparity);
                end else begin
                    want = expected_path_costs.pop_front();
                    if (got.path_cost !== want.path_cost ||
                        got.disparity_index !== want.disparity_index ||
                        got.last_disparity !== want.last_disparity) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"path cost word %0d mismatch: expected cost %0d ",
                                      "index %0d last %0b, got cost %0d index %0d last %0b"},
                                     checked, want.path_cost, want.disparity_index,
                                     want.last_disparity, got.path_cost,
                                     got.disparity_index, got.last_disparity);
                    end
                    checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgm_pca_pkg::CFG_SMALL_PENALTY:   small_penalty   = i_cfg_data;
                    sgm_pca_pkg::CFG_LARGE_PENALTY:   large_penalty   = i_cfg_data;
                    sgm_pca_pkg::CFG_DISPARITY_COUNT: disparity_count = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                aggregate_cost(i_unary_cost, i_path_start);
        end
        in_flight <= expected_path_costs.size();
    end

endmodule

// File: tb/sv/sgm_path_cost_aggregation_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for sgm_path_cost_aggregation_top: clock, reset, register writes,
// cost word stimulus, output stall and the verdict. Uses sgm_path_cost_checker and
// sgm_pca_pkg.
module sgm_path_cost_aggregation_top_tb;

    localparam int MAXD              = sgm_pca_pkg::MAX_DISPARITIES_DEF;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int HOLD_CYCLES       = 60;
    localparam int SMALL_PHASE_WORDS = 16;
    localparam int RANDOM_PHASES     = 16;
    localparam int HEAVY_PIXELS      = 8;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [sgm_pca_pkg::CFG_INDEX_W-1:0]   cfg_index = sgm_pca_pkg::CFG_SMALL_PENALTY;
    logic [sgm_pca_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic [sgm_pca_pkg::UNARY_W-1:0]       unary_cost = '0;
    logic                                  path_start = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [sgm_pca_pkg::COST_BITS_DEF-1:0] path_cost;
    logic [sgm_pca_pkg::INDEX_W-1:0]       disparity_index;
    logic                                  last_disparity;
    int                                    fail_count;
    int                                    pending;
    int                                    checked;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    // The sender keeps its own view of the disparity counter so that it never makes a
    // non-start word read a cost level that no pixel has written yet.
    int gen_next = 0;
    int gen_levels = sgm_pca_pkg::DISPARITY_COUNT_RST;
    bit written [MAXD];
    bit pixel_start = 1'b0;
    int words_sent = 0;
    int input_held = 0;
    int phases = 0;

    always #2 clk = ~clk;

    sgm_path_cost_aggregation_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_unary_cost      (unary_cost),
        .i_path_start      (path_start),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_path_cost       (path_cost),
        .o_disparity_index (disparity_index),
        .o_last_disparity  (last_disparity)
    );

    sgm_path_cost_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_unary_cost      (unary_cost),
        .i_path_start      (path_start),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_path_cost       (path_cost),
        .i_disparity_index (disparity_index),
        .i_last_disparity  (last_disparity),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles without finishing", cycle_count);
        $display("sgm_path_cost_aggregation_top_tb NOT OK");
        $finish;
    end

    task automatic send_word(input logic [sgm_pca_pkg::UNARY_W-1:0] unary,
                             input bit want_start);
        int d;
        int gap;
        bit is_last;
        bit start;
        d = (gen_next >= MAXD) ? MAXD - 1 : gen_next;
        is_last = (d >= gen_levels - 1);
        start = want_start;
        if (!written[d] || (d > 0 && !written[d - 1]) || (!is_last && !written[d + 1]))
            start = 1'b1;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        unary_cost <= unary;
        path_start <= start;
        @(posedge clk);
        while (in_stall) begin
            input_held++;
            @(posedge clk);
        end
        written[d] = 1'b1;
        gen_next = is_last ? 0 : d + 1;
        words_sent++;
    endtask

    task automatic send_random_words(input int count);
        logic [sgm_pca_pkg::UNARY_W-1:0] u;
        for (int n = 0; n < count; n++) begin
            if (gen_next == 0)
                pixel_start = ($urandom_range(9) == 0);
            case ($urandom_range(7))
                0:       u = '0;
                1:       u = '1;
                default: u = sgm_pca_pkg::UNARY_W'($urandom);
            endcase
            // Now and then one word of a pixel goes against the pixel's start flag.
            send_word(u, pixel_start ^ ($urandom_range(31) == 0));
        end
    endtask

    task automatic wait_path_costs_drained();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_penalties(input logic [7:0] sp, input logic [7:0] lp,
                                     input logic [7:0] dc);
        cfg_we    <= 1'b1;
        cfg_index <= sgm_pca_pkg::CFG_SMALL_PENALTY;
        cfg_data  <= sp;
        @(posedge clk);
        cfg_index <= sgm_pca_pkg::CFG_LARGE_PENALTY;
        cfg_data  <= lp;
        @(posedge clk);
        cfg_index <= sgm_pca_pkg::CFG_DISPARITY_COUNT;
        cfg_data  <= dc;
        @(posedge clk);
        cfg_we <= 1'b0;
        gen_levels = (dc < 2) ? 2 : (dc > MAXD) ? MAXD : dc;
    endtask

    initial begin
        int words;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: three start words, none of them the end of a pixel.
        send_word(8'd0, 1'b1);
        send_word(8'd255, 1'b1);
        send_word(8'd128, 1'b1);
        wait_path_costs_drained();
        // The pixel is at level three when the count drops to three, so the next word
        // closes it.
        program_penalties(8'd0, 8'd255, 8'd3);
        send_word(8'd77, 1'b1);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd7, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd2, 1'b0);
        send_word(8'd3, 1'b0);
        wait_path_costs_drained();
        // A count below two works as two; the second pixel mixes start and non-start.
        program_penalties(8'd255, 8'd0, 8'd1);
        send_word(8'd10, 1'b0);
        send_word(8'd20, 1'b0);
        send_word(8'd5, 1'b1);
        send_word(8'd9, 1'b0);
        wait_path_costs_drained();
        program_penalties(8'd3, 8'd200, 8'd4);
        send_word(8'd40, 1'b0);
        send_word(8'd41, 1'b0);
        wait_path_costs_drained();
        // Lowered count inside a pixel: this non-start word at level two is the last.
        program_penalties(8'd3, 8'd200, 8'd2);
        send_word(8'd42, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_path_costs_drained();
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct = 62;
                    receiver_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 62;
                end
                default: begin
                    sender_idle_pct = 32;
                    receiver_stall_pct <= 32;
                end
            endcase
            words = SMALL_PHASE_WORDS;
            case (p)
                0: program_penalties(8'd0, 8'd0, 8'd2);
                1: program_penalties(8'd255, 8'd255, 8'd3);
                2: begin
                    program_penalties(8'd17, 8'd90, 8'd255);
                    words = 40;
                end
                3: begin
                    program_penalties(8'd255, 8'd0, MAXD[7:0]);
                    words = 2 * MAXD;
                end
                4: program_penalties(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0);
                5: program_penalties(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1);
                default: program_penalties(8'($urandom_range(255)), 8'($urandom_range(255)),
                                           8'($urandom_range(2, 9)));
            endcase
            // The receiver holds off while the sender keeps offering words.
            if (p % 8 == 4)
                hold_req <= hold_req + 1;
            send_random_words(words);
            phases++;
        end

        // Two levels, maximum cost words and maximum penalties, so the costs climb as
        // fast as the block allows.
        wait_path_costs_drained();
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        program_penalties(8'd255, 8'd255, 8'd2);
        repeat (3) send_word(8'd255, 1'b1);
        repeat (2 * HEAVY_PIXELS) send_word(8'd255, 1'b0);
        phases++;
        wait_path_costs_drained();

        $display("sent %0d cost words over %0d setting phases, the last one with %s",
                 words_sent, phases, "maximum costs and penalties");
        $display("checked %0d path cost words; the input stalled for %0d cycles",
                 checked, input_held);
        if (fail_count == 0 && pending == 0)
            $display("sgm_path_cost_aggregation_top_tb OK");
        else
            $display("sgm_path_cost_aggregation_top_tb NOT OK");
        $finish;
    end

endmodule

// File: sgm_path_cost_aggregation_top.f
sv/sgm_pca_pkg.sv
sv/sgm_path_cost_aggregation_top.sv
sv/sgm_pca_checker.sv
tb/sv/sgm_path_cost_checker.sv
tb/sv/sgm_path_cost_aggregation_top_tb.sv
